// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rwnh_pkg.sv =====
`default_nettype none
package rwnh_pkg;

    // Defaults
    localparam int WALLS_DEF = 16;
    localparam logic [45:0] MAX_DIST_RESET = 46'd65536000000;

    // Quotient bits of the hit-point divider
    localparam int Q_BITS = 25;

    // Register indexes
    localparam logic [1:0] REG_WALL_COUNT = 2'd0;
    localparam logic [1:0] REG_MAX_DIST   = 2'd1;

    // Result status codes
    localparam logic [1:0] STAT_NONE   = 2'd0;
    localparam logic [1:0] STAT_HIT    = 2'd1;
    localparam logic [1:0] STAT_BEYOND = 2'd2;

    // Datapath step codes
    localparam logic [4:0] CMD_NOP   = 5'd0;
    localparam logic [4:0] CMD_INIT  = 5'd1;
    localparam logic [4:0] CMD_READ  = 5'd2;
    localparam logic [4:0] CMD_DIFF  = 5'd3;
    localparam logic [4:0] CMD_FDX   = 5'd4;
    localparam logic [4:0] CMD_EDY   = 5'd5;
    localparam logic [4:0] CMD_AYDX  = 5'd6;
    localparam logic [4:0] CMD_AXDY  = 5'd7;
    localparam logic [4:0] CMD_FAX   = 5'd8;
    localparam logic [4:0] CMD_EAY   = 5'd9;
    localparam logic [4:0] CMD_CHK   = 5'd10;
    localparam logic [4:0] CMD_TLO   = 5'd11;
    localparam logic [4:0] CMD_THI   = 5'd12;
    localparam logic [4:0] CMD_NUM   = 5'd13;
    localparam logic [4:0] CMD_DINIT = 5'd14;
    localparam logic [4:0] CMD_DSTEP = 5'd15;
    localparam logic [4:0] CMD_HX    = 5'd16;
    localparam logic [4:0] CMD_HY    = 5'd17;
    localparam logic [4:0] CMD_SQX   = 5'd18;
    localparam logic [4:0] CMD_SQY   = 5'd19;
    localparam logic [4:0] CMD_CMP   = 5'd20;
    localparam logic [4:0] CMD_FIN   = 5'd21;

    // Controller to datapath
    typedef struct packed {
        logic [4:0] step;
        logic       axis_f;  // TLO/THI use |F| instead of |E|
        logic       load;    // write wall table
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit_ok;        // valid during CMD_CHK
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rwnh_dp.sv =====
`default_nettype none
module rwnh_dp #(
    parameter int WALLS = rwnh_pkg::WALLS_DEF
) (
    input  wire                          clk,
    input  rwnh_pkg::dp_cmd_t            cmd,
    input  wire [$clog2(WALLS+1)-1:0]    idx,
    input  wire [3:0]                    wall_index,
    input  wire signed [23:0]            wall_x1,
    input  wire signed [23:0]            wall_y1,
    input  wire signed [23:0]            wall_x2,
    input  wire signed [23:0]            wall_y2,
    input  wire signed [23:0]            ray_x,
    input  wire signed [23:0]            ray_y,
    input  wire signed [15:0]            dir_x,
    input  wire signed [15:0]            dir_y,
    input  wire [45:0]                   max_dist_sq,
    output rwnh_pkg::dp_stat_t           stat,
    output logic [1:0]                   status,
    output logic signed [23:0]           end_x,
    output logic signed [23:0]           end_y,
    output logic [3:0]                   hit_wall
);

    localparam int CW = $clog2(WALLS + 1);
    localparam int IW = (WALLS > 1) ? $clog2(WALLS) : 1;
    localparam int QB = rwnh_pkg::Q_BITS;

    // Wall table
    logic [47:0] start_mem [WALLS];
    logic [47:0] end_mem   [WALLS];
    logic [47:0] start_q_reg, end_q_reg;

    // Ray and running best
    logic signed [23:0] rx_reg, ry_reg, bx_reg, by_reg, x1_reg, y1_reg, hx_reg, hy_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [45:0]        best_reg;
    logic [CW-1:0]      bw_reg;
    logic               any_reg, found_reg;

    // Intersection terms
    logic signed [24:0] e_reg, f_reg, ax_reg, ay_reg;
    logic signed [51:0] prod_reg, acc_reg;
    logic signed [41:0] dn_reg, tn_reg;
    logic [41:0]        dn_abs_reg, tn_abs_reg;
    logic [65:0]        num_reg;
    logic [41:0]        rem_reg;
    logic [QB-1:0]      dvl_reg;

    logic signed [25:0] mul_a, mul_b, mag_sel, ddx, ddy;
    logic signed [24:0] e_mag, f_mag;
    logic signed [51:0] un_raw, un_n, len;
    logic signed [41:0] dn_n, tn_n;
    logic [42:0]        div_t;
    logic               div_ge;
    logic signed [16:0] rnd_x, rnd_y;
    logic signed [24:0] sum_x, sum_y;
    logic signed [23:0] sat_x, sat_y;

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && (32'(wall_index) < WALLS))
        begin
            start_mem[IW'(wall_index)] <= {wall_y1, wall_x1};
            end_mem[IW'(wall_index)]   <= {wall_y2, wall_x2};
        end
        if (cmd.step == rwnh_pkg::CMD_READ)
        begin
            start_q_reg <= start_mem[idx[IW-1:0]];
            end_q_reg   <= end_mem[idx[IW-1:0]];
        end
    end

    // Operand magnitudes and distance offsets
    assign e_mag   = e_reg[24] ? -e_reg : e_reg;
    assign f_mag   = f_reg[24] ? -f_reg : f_reg;
    assign mag_sel = cmd.axis_f ? 26'(f_mag) : 26'(e_mag);
    assign ddx     = 26'(hx_reg) - 26'(rx_reg);
    assign ddy     = 26'(hy_reg) - 26'(ry_reg);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            rwnh_pkg::CMD_FDX:  begin mul_a = 26'(f_reg);  mul_b = 26'(dx_reg); end
            rwnh_pkg::CMD_EDY:  begin mul_a = 26'(e_reg);  mul_b = 26'(dy_reg); end
            rwnh_pkg::CMD_AYDX: begin mul_a = 26'(ay_reg); mul_b = 26'(dx_reg); end
            rwnh_pkg::CMD_AXDY: begin mul_a = 26'(ax_reg); mul_b = 26'(dy_reg); end
            rwnh_pkg::CMD_FAX:  begin mul_a = 26'(f_reg);  mul_b = 26'(ax_reg); end
            rwnh_pkg::CMD_EAY:  begin mul_a = 26'(e_reg);  mul_b = 26'(ay_reg); end
            rwnh_pkg::CMD_TLO:
            begin
                mul_a = $signed({5'd0, tn_abs_reg[20:0]});
                mul_b = mag_sel;
            end
            rwnh_pkg::CMD_THI:
            begin
                mul_a = $signed({5'd0, tn_abs_reg[41:21]});
                mul_b = mag_sel;
            end
            rwnh_pkg::CMD_SQX:  begin mul_a = ddx; mul_b = ddx; end
            rwnh_pkg::CMD_SQY:  begin mul_a = ddy; mul_b = ddy; end
            default:            begin mul_a = '0;  mul_b = '0;  end
        endcase
    end

    // Sign normalization and hit test
    assign un_raw = acc_reg - prod_reg;
    assign dn_n   = dn_reg[41] ? -dn_reg : dn_reg;
    assign tn_n   = dn_reg[41] ? -tn_reg : tn_reg;
    assign un_n   = dn_reg[41] ? -un_raw : un_raw;
    assign stat.hit_ok = (dn_reg != '0) && !tn_n[41] && (tn_n <= dn_n)
                         && !un_n[51] && (un_n != '0);

    // Restoring divider step
    assign div_t  = {rem_reg, dvl_reg[QB-1]};
    assign div_ge = div_t >= {1'b0, dn_abs_reg};

    // Squared distance
    assign len = acc_reg + prod_reg;

    // Origin plus rounded direction, saturated
    assign rnd_x = (17'(dx_reg) + 17'sd32) >>> 6;
    assign rnd_y = (17'(dy_reg) + 17'sd32) >>> 6;
    assign sum_x = 25'(rx_reg) + 25'(rnd_x);
    assign sum_y = 25'(ry_reg) + 25'(rnd_y);
    assign sat_x = (sum_x[24] != sum_x[23]) ? (sum_x[24] ? 24'sh800000 : 24'sh7FFFFF)
                                            : sum_x[23:0];
    assign sat_y = (sum_y[24] != sum_y[23]) ? (sum_y[24] ? 24'sh800000 : 24'sh7FFFFF)
                                            : sum_y[23:0];

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.step)
            rwnh_pkg::CMD_INIT:
            begin
                rx_reg    <= ray_x;
                ry_reg    <= ray_y;
                dx_reg    <= dir_x;
                dy_reg    <= dir_y;
                best_reg  <= max_dist_sq;
                bw_reg    <= '0;
                any_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            rwnh_pkg::CMD_DIFF:
            begin
                x1_reg <= start_q_reg[23:0];
                y1_reg <= start_q_reg[47:24];
                e_reg  <= 25'($signed(start_q_reg[23:0])) - 25'($signed(end_q_reg[23:0]));
                f_reg  <= 25'($signed(start_q_reg[47:24])) - 25'($signed(end_q_reg[47:24]));
                ax_reg <= 25'($signed(start_q_reg[23:0])) - 25'(rx_reg);
                ay_reg <= 25'($signed(start_q_reg[47:24])) - 25'(ry_reg);
            end
            rwnh_pkg::CMD_EDY:  acc_reg <= prod_reg;
            rwnh_pkg::CMD_AYDX: dn_reg  <= 42'(acc_reg - prod_reg);
            rwnh_pkg::CMD_AXDY: acc_reg <= prod_reg;
            rwnh_pkg::CMD_FAX:  tn_reg  <= 42'(acc_reg - prod_reg);
            rwnh_pkg::CMD_EAY:  acc_reg <= prod_reg;
            rwnh_pkg::CMD_CHK:
            begin
                dn_abs_reg <= dn_n;
                tn_abs_reg <= tn_n;
            end
            rwnh_pkg::CMD_THI:  acc_reg <= prod_reg + 52'(dn_abs_reg >> 1);
            rwnh_pkg::CMD_NUM:
                num_reg <= 66'($unsigned(acc_reg)) + (66'($unsigned(prod_reg)) << 21);
            rwnh_pkg::CMD_DINIT:
            begin
                rem_reg <= 42'(num_reg >> QB);
                dvl_reg <= num_reg[QB-1:0];
            end
            rwnh_pkg::CMD_DSTEP:
            begin
                rem_reg <= div_ge ? 42'(div_t - {1'b0, dn_abs_reg}) : 42'(div_t);
                dvl_reg <= {dvl_reg[QB-2:0], div_ge};
            end
            rwnh_pkg::CMD_HX:
                hx_reg <= e_reg[24] ? 24'(26'(x1_reg) + {1'b0, dvl_reg})
                                    : 24'(26'(x1_reg) - {1'b0, dvl_reg});
            rwnh_pkg::CMD_HY:
                hy_reg <= f_reg[24] ? 24'(26'(y1_reg) + {1'b0, dvl_reg})
                                    : 24'(26'(y1_reg) - {1'b0, dvl_reg});
            rwnh_pkg::CMD_SQY:  acc_reg <= prod_reg;
            rwnh_pkg::CMD_CMP:
            begin
                any_reg <= 1'b1;
                if ($unsigned(len) < {6'd0, best_reg})
                begin
                    best_reg  <= len[45:0];
                    bx_reg    <= hx_reg;
                    by_reg    <= hy_reg;
                    bw_reg    <= idx;
                    found_reg <= 1'b1;
                end
            end
            rwnh_pkg::CMD_FIN:
            begin
                if (found_reg)
                begin
                    status   <= rwnh_pkg::STAT_HIT;
                    end_x    <= bx_reg;
                    end_y    <= by_reg;
                    hit_wall <= 4'(bw_reg);
                end
                else if (any_reg)
                begin
                    status   <= rwnh_pkg::STAT_BEYOND;
                    end_x    <= sat_x;
                    end_y    <= sat_y;
                    hit_wall <= '0;
                end
                else
                begin
                    status   <= rwnh_pkg::STAT_NONE;
                    end_x    <= rx_reg;
                    end_y    <= ry_reg;
                    hit_wall <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rwnh_ctrl.sv =====
`default_nettype none
module rwnh_ctrl #(
    parameter int WALLS = rwnh_pkg::WALLS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire                          op,
    input  wire [4:0]                    wall_count,
    input  rwnh_pkg::dp_stat_t           stat,
    output logic                         busy,
    output logic                         done,
    output rwnh_pkg::dp_cmd_t            cmd,
    output logic [$clog2(WALLS+1)-1:0]   idx
);

    localparam int CW = $clog2(WALLS + 1);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_READ    = 5'd1;
    localparam logic [4:0] ST_DIFF    = 5'd2;
    localparam logic [4:0] ST_FDX     = 5'd3;
    localparam logic [4:0] ST_EDY     = 5'd4;
    localparam logic [4:0] ST_AYDX    = 5'd5;
    localparam logic [4:0] ST_AXDY    = 5'd6;
    localparam logic [4:0] ST_FAX     = 5'd7;
    localparam logic [4:0] ST_EAY     = 5'd8;
    localparam logic [4:0] ST_CHK     = 5'd9;
    localparam logic [4:0] ST_TLO_E   = 5'd10;
    localparam logic [4:0] ST_THI_E   = 5'd11;
    localparam logic [4:0] ST_NUM_E   = 5'd12;
    localparam logic [4:0] ST_DINIT_E = 5'd13;
    localparam logic [4:0] ST_DIV_E   = 5'd14;
    localparam logic [4:0] ST_HX      = 5'd15;
    localparam logic [4:0] ST_TLO_F   = 5'd16;
    localparam logic [4:0] ST_THI_F   = 5'd17;
    localparam logic [4:0] ST_NUM_F   = 5'd18;
    localparam logic [4:0] ST_DINIT_F = 5'd19;
    localparam logic [4:0] ST_DIV_F   = 5'd20;
    localparam logic [4:0] ST_HY      = 5'd21;
    localparam logic [4:0] ST_SQX     = 5'd22;
    localparam logic [4:0] ST_SQY     = 5'd23;
    localparam logic [4:0] ST_CMP     = 5'd24;
    localparam logic [4:0] ST_NEXT    = 5'd25;
    localparam logic [4:0] ST_FIN     = 5'd26;

    localparam logic [4:0] DIV_LAST = 5'(rwnh_pkg::Q_BITS - 1);

    logic [4:0]    state_reg, state_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next, n_reg, n_next;
    logic          done_reg, done_next;
    logic [CW-1:0] n_cap;

    // Walls tested: configured count, capped at the table depth
    assign n_cap = (32'(wall_count) < WALLS) ? CW'(wall_count) : CW'(WALLS);

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign idx  = idx_reg;

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        done_next  = 1'b0;
        cmd.step   = rwnh_pkg::CMD_NOP;
        cmd.axis_f = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !op)
                begin
                    cmd.load = 1'b1;
                end
                else if (start)
                begin
                    cmd.step   = rwnh_pkg::CMD_INIT;
                    idx_next   = '0;
                    n_next     = n_cap;
                    state_next = (n_cap == '0) ? ST_FIN : ST_READ;
                end
            end
            ST_READ:    begin cmd.step = rwnh_pkg::CMD_READ; state_next = ST_DIFF; end
            ST_DIFF:    begin cmd.step = rwnh_pkg::CMD_DIFF; state_next = ST_FDX;  end
            ST_FDX:     begin cmd.step = rwnh_pkg::CMD_FDX;  state_next = ST_EDY;  end
            ST_EDY:     begin cmd.step = rwnh_pkg::CMD_EDY;  state_next = ST_AYDX; end
            ST_AYDX:    begin cmd.step = rwnh_pkg::CMD_AYDX; state_next = ST_AXDY; end
            ST_AXDY:    begin cmd.step = rwnh_pkg::CMD_AXDY; state_next = ST_FAX;  end
            ST_FAX:     begin cmd.step = rwnh_pkg::CMD_FAX;  state_next = ST_EAY;  end
            ST_EAY:     begin cmd.step = rwnh_pkg::CMD_EAY;  state_next = ST_CHK;  end
            ST_CHK:
            begin
                cmd.step   = rwnh_pkg::CMD_CHK;
                state_next = stat.hit_ok ? ST_TLO_E : ST_NEXT;
            end
            ST_TLO_E:   begin cmd.step = rwnh_pkg::CMD_TLO; state_next = ST_THI_E; end
            ST_THI_E:   begin cmd.step = rwnh_pkg::CMD_THI; state_next = ST_NUM_E; end
            ST_NUM_E:   begin cmd.step = rwnh_pkg::CMD_NUM; state_next = ST_DINIT_E; end
            ST_DINIT_E:
            begin
                cmd.step   = rwnh_pkg::CMD_DINIT;
                cnt_next   = '0;
                state_next = ST_DIV_E;
            end
            ST_DIV_E:
            begin
                cmd.step = rwnh_pkg::CMD_DSTEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_HX;
                end
            end
            ST_HX:      begin cmd.step = rwnh_pkg::CMD_HX; state_next = ST_TLO_F; end
            ST_TLO_F:
            begin
                cmd.step   = rwnh_pkg::CMD_TLO;
                cmd.axis_f = 1'b1;
                state_next = ST_THI_F;
            end
            ST_THI_F:
            begin
                cmd.step   = rwnh_pkg::CMD_THI;
                cmd.axis_f = 1'b1;
                state_next = ST_NUM_F;
            end
            ST_NUM_F:   begin cmd.step = rwnh_pkg::CMD_NUM; state_next = ST_DINIT_F; end
            ST_DINIT_F:
            begin
                cmd.step   = rwnh_pkg::CMD_DINIT;
                cnt_next   = '0;
                state_next = ST_DIV_F;
            end
            ST_DIV_F:
            begin
                cmd.step = rwnh_pkg::CMD_DSTEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_HY;
                end
            end
            ST_HY:      begin cmd.step = rwnh_pkg::CMD_HY;  state_next = ST_SQX;  end
            ST_SQX:     begin cmd.step = rwnh_pkg::CMD_SQX; state_next = ST_SQY;  end
            ST_SQY:     begin cmd.step = rwnh_pkg::CMD_SQY; state_next = ST_CMP;  end
            ST_CMP:     begin cmd.step = rwnh_pkg::CMD_CMP; state_next = ST_NEXT; end
            ST_NEXT:
            begin
                if ((32'(idx_reg) + 1) == 32'(n_reg))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FIN:
            begin
                cmd.step   = rwnh_pkg::CMD_FIN;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ray_wall_nearest_hit.sv =====
// Wall load (op 0): taken in the accept cycle, no result, busy stays low.
// Ray cast (op 1): done rises once every configured wall has been tested; a wall that passes
// the hit test also runs the divider for both hit coordinates, while a wall that misses does not.
// Busy drops with done, so the next transaction is taken on the strobe edge.
// One shared 26x26 multiplier and one bit-per-cycle divider (two 25-step runs) set the cost.
// Reset clears the controller and sets config defaults; the wall table is undefined until loaded.
`default_nettype none
module ray_wall_nearest_hit #(
    parameter int WALLS = rwnh_pkg::WALLS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    output logic                done,
    input  wire                 op,
    input  wire [3:0]           wall_index,
    input  wire signed [23:0]   wall_x1,
    input  wire signed [23:0]   wall_y1,
    input  wire signed [23:0]   wall_x2,
    input  wire signed [23:0]   wall_y2,
    input  wire signed [23:0]   ray_x,
    input  wire signed [23:0]   ray_y,
    input  wire signed [15:0]   dir_x,
    input  wire signed [15:0]   dir_y,
    output logic [1:0]          status,
    output logic signed [23:0]  end_x,
    output logic signed [23:0]  end_y,
    output logic [3:0]          hit_wall,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [45:0]          cfg_data
);

    localparam int CW = $clog2(WALLS + 1);

    logic [4:0]         wall_count_reg;
    logic [45:0]        max_dist_reg;
    rwnh_pkg::dp_cmd_t  cmd;
    rwnh_pkg::dp_stat_t stat;
    logic [CW-1:0]      idx;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_count_reg <= '0;
            max_dist_reg   <= rwnh_pkg::MAX_DIST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == rwnh_pkg::REG_WALL_COUNT)
            begin
                wall_count_reg <= cfg_data[4:0];
            end
            else if (cfg_index == rwnh_pkg::REG_MAX_DIST)
            begin
                max_dist_reg <= cfg_data;
            end
        end
    end

    rwnh_ctrl #(.WALLS(WALLS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .wall_count (wall_count_reg),
        .stat       (stat),
        .busy       (busy),
        .done       (done),
        .cmd        (cmd),
        .idx        (idx)
    );

    rwnh_dp #(.WALLS(WALLS)) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .idx         (idx),
        .wall_index  (wall_index),
        .wall_x1     (wall_x1),
        .wall_y1     (wall_y1),
        .wall_x2     (wall_x2),
        .wall_y2     (wall_y2),
        .ray_x       (ray_x),
        .ray_y       (ray_y),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .max_dist_sq (max_dist_reg),
        .stat        (stat),
        .status      (status),
        .end_x       (end_x),
        .end_y       (end_y),
        .hit_wall    (hit_wall)
    );

`include "assert_macros.svh"

    // Result strobe lasts one cycle
    `AST_NEXT(a_done_pulse, done, !done)
    // An accepted cast keeps the block busy
    `AST_NEXT(a_cast_busy, start && !busy && op, busy)
    // A load never starts work
    `AST_NEXT(a_load_idle, start && !busy && !op, !busy && !done)
    // Wall index is reported only with a hit
    `AST_SAME(a_wall_zero, done && (status != rwnh_pkg::STAT_HIT), hit_wall == 4'd0)

endmodule
`default_nettype wire
